### rtl/target_pair_pose_estimator_macros.svh
// Assertion helpers used by the top-level RTL.
`ifndef TARGET_PAIR_POSE_ESTIMATOR_MACROS_SVH
`define TARGET_PAIR_POSE_ESTIMATOR_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define TPPE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define TPPE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TPPE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define TPPE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/tppe_pkg.sv
`default_nettype none
package tppe_pkg;
	localparam int PIXEL_BITS      = 12;
	localparam int ANGLE_FRAC_BITS = 8;
	localparam int FOCAL_BITS      = 16;
	localparam int WIDTH_BITS      = 13;
	localparam int TRUE_BITS       = 16;
	localparam int RANGE_BITS      = TRUE_BITS + FOCAL_BITS;
	localparam int DIV_BITS        = RANGE_BITS + PIXEL_BITS;
	localparam int LAT_BITS        = DIV_BITS + 1;
	localparam int ATAN_IN_BITS    = DIV_BITS + 1;
	localparam int NORM_BITS       = 39;
	localparam int NORM_STAGES     = 6;
	localparam int CORDIC_STEPS    = 28;
	localparam int CORDIC_BITS     = NORM_BITS + 3;
	localparam int ZFRAC           = 24;
	localparam int Z_BITS          = 33;
	localparam int ANGLE_BITS      = 16;
	localparam int ANGLE_MAG_BITS  = 7 + ANGLE_FRAC_BITS;
	localparam logic [ANGLE_MAG_BITS-1:0] ANGLE_TOP = ANGLE_MAG_BITS'(90 << ANGLE_FRAC_BITS);
	localparam int ATAN_LANES      = 3;
	localparam int LANE_YAW_L      = 0;
	localparam int LANE_YAW_R      = 1;
	localparam int LANE_SKEW       = 2;
	localparam int MEAN_RANGE_BITS = 20;
	localparam int MEAN_LAT_BITS   = 21;
	localparam int APB_ADDR_BITS   = 3;
	localparam int APB_DATA_BITS   = 32;
	localparam int REG_IDX_BITS    = APB_ADDR_BITS - 2;
	localparam logic [FOCAL_BITS-1:0] FOCAL_RESET = FOCAL_BITS'(600);
	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(640);

	// atan(2^-i) in degrees, ZFRAC fraction bits
	localparam logic signed [Z_BITS-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		33'sd754974720, 33'sd445687602, 33'sd235489088, 33'sd119537938,
		33'sd60000934, 33'sd30029717, 33'sd15018523, 33'sd7509720,
		33'sd3754917, 33'sd1877466, 33'sd938734, 33'sd469367,
		33'sd234684, 33'sd117342, 33'sd58671, 33'sd29335,
		33'sd14668, 33'sd7334, 33'sd3667, 33'sd1833,
		33'sd917, 33'sd458, 33'sd229, 33'sd115,
		33'sd57, 33'sd29, 33'sd14, 33'sd7
	};

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_FOCAL = 1'b0,
		REG_WIDTH = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] adx_l;
		logic [PIXEL_BITS-1:0] adx_r;
		logic                  neg_l;
		logic                  neg_r;
		logic [FOCAL_BITS-1:0] focal;
		logic [RANGE_BITS-1:0] rng_l;
		logic [RANGE_BITS-1:0] rng_r;
	} div_side_t;

	typedef struct packed {
		logic                     neg_yaw_l;
		logic                     neg_yaw_r;
		logic                     neg_skew;
		logic [RANGE_BITS:0]      rng_sum;
		logic signed [LAT_BITS:0] lat_sum;
	} atan_side_t;
endpackage
`default_nettype wire

### rtl/tppe_div2.sv
`default_nettype none
// Two-lane restoring divider, one quotient bit per stage.
module tppe_div2 (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_vld,
	input  logic [tppe_pkg::DIV_BITS-1:0]       dvd_l,
	input  logic [tppe_pkg::DIV_BITS-1:0]       dvd_r,
	input  logic [tppe_pkg::FOCAL_BITS-1:0]     dvs_l,
	input  logic [tppe_pkg::FOCAL_BITS-1:0]     dvs_r,
	input  tppe_pkg::div_side_t                 side_in,
	output logic                                out_vld,
	output logic [tppe_pkg::DIV_BITS-1:0]       quo_l,
	output logic [tppe_pkg::DIV_BITS-1:0]       quo_r,
	output tppe_pkg::div_side_t                 side_out
);
	localparam int N = tppe_pkg::DIV_BITS;
	localparam int D = tppe_pkg::FOCAL_BITS;

	logic                vld_s  [N];
	tppe_pkg::div_side_t side_s [N];
	logic [N-1:0]        acc_s  [2][N];
	logic [D-1:0]        rem_s  [2][N];
	logic [D-1:0]        dvs_s  [2][N];
	logic [N-1:0]        dvd_in [2];
	logic [D-1:0]        dvs_in [2];

	assign dvd_in[0] = dvd_l;
	assign dvd_in[1] = dvd_r;
	assign dvs_in[0] = dvs_l;
	assign dvs_in[1] = dvs_r;

	for (genvar g = 0; g < N; g++) begin : g_stage
		logic                vld_in;
		tppe_pkg::div_side_t side_prev;
		if (g == 0) begin : g_head
			assign vld_in    = in_vld;
			assign side_prev = side_in;
		end else begin : g_body
			assign vld_in    = vld_s[g-1];
			assign side_prev = side_s[g-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[g] <= side_prev;
			end
		end

		for (genvar ln = 0; ln < 2; ln++) begin : g_lane
			logic [N-1:0] acc_in;
			logic [D-1:0] rem_in;
			logic [D-1:0] d_in;
			logic [D:0]   trial;
			logic         ge;
			if (g == 0) begin : g_head
				assign acc_in = dvd_in[ln];
				assign rem_in = '0;
				assign d_in   = dvs_in[ln];
			end else begin : g_body
				assign acc_in = acc_s[ln][g-1];
				assign rem_in = rem_s[ln][g-1];
				assign d_in   = dvs_s[ln][g-1];
			end
			assign trial = {rem_in, acc_in[N-1]};
			assign ge    = trial >= {1'b0, d_in};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[ln][g] <= ge ? D'(trial - {1'b0, d_in}) : trial[D-1:0];
					acc_s[ln][g] <= {acc_in[N-2:0], ge};
					dvs_s[ln][g] <= d_in;
				end
			end
		end
	end

	assign out_vld  = vld_s[N-1];
	assign quo_l    = acc_s[0][N-1];
	assign quo_r    = acc_s[1][N-1];
	assign side_out = side_s[N-1];
endmodule
`default_nettype wire

### rtl/tppe_atan3.sv
`default_nettype none
// Three-lane atan(num/den) in degrees, 0..90: normalize, CORDIC vectoring, round.
module tppe_atan3 (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    in_vld,
	input  logic [tppe_pkg::ATAN_IN_BITS-1:0]       num [tppe_pkg::ATAN_LANES],
	input  logic [tppe_pkg::ATAN_IN_BITS-1:0]       den [tppe_pkg::ATAN_LANES],
	input  tppe_pkg::atan_side_t                    side_in,
	output logic                                    out_vld,
	output logic [tppe_pkg::ANGLE_MAG_BITS-1:0]     ang [tppe_pkg::ATAN_LANES],
	output tppe_pkg::atan_side_t                    side_out
);
	localparam int W   = tppe_pkg::ATAN_IN_BITS;
	localparam int NS  = tppe_pkg::NORM_STAGES;
	localparam int NC  = tppe_pkg::CORDIC_STEPS;
	localparam int L   = NS + NC + 1;
	localparam int CB  = tppe_pkg::CORDIC_BITS;
	localparam int ZB  = tppe_pkg::Z_BITS;
	localparam int NB  = tppe_pkg::NORM_BITS;
	localparam int AB  = tppe_pkg::ANGLE_MAG_BITS;
	localparam int ZSH = tppe_pkg::ZFRAC - tppe_pkg::ANGLE_FRAC_BITS;
	localparam int NL  = tppe_pkg::ATAN_LANES;

	logic                 vld_s  [L];
	tppe_pkg::atan_side_t side_s [L];
	logic [W-1:0]         nn_s   [NL][NS];
	logic [W-1:0]         nd_s   [NL][NS];
	logic                 nz_s   [NL][NS];
	logic signed [CB-1:0] x_s    [NL][NC];
	logic signed [CB-1:0] y_s    [NL][NC];
	logic signed [ZB-1:0] z_s    [NL][NC];
	logic                 cz_s   [NL][NC];
	logic [AB-1:0]        ang_s  [NL];

	for (genvar s = 0; s < L; s++) begin : g_ctl
		logic                 vld_in;
		tppe_pkg::atan_side_t side_prev;
		if (s == 0) begin : g_head
			assign vld_in    = in_vld;
			assign side_prev = side_in;
		end else begin : g_body
			assign vld_in    = vld_s[s-1];
			assign side_prev = side_s[s-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else if (en) begin
				vld_s[s] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[s] <= side_prev;
			end
		end
	end

	for (genvar ln = 0; ln < NL; ln++) begin : g_lane
		// shift both operands left until the larger one has its MSB at the top
		for (genvar n = 0; n < NS; n++) begin : g_norm
			localparam int SH = 1 << (NS - 1 - n);
			logic [W-1:0] n_in;
			logic [W-1:0] d_in;
			logic         nz_in;
			logic         top_zero;
			if (n == 0) begin : g_head
				assign n_in  = num[ln];
				assign d_in  = den[ln];
				assign nz_in = (num[ln] != '0);
			end else begin : g_body
				assign n_in  = nn_s[ln][n-1];
				assign d_in  = nd_s[ln][n-1];
				assign nz_in = nz_s[ln][n-1];
			end
			assign top_zero = (n_in[W-1 -: SH] | d_in[W-1 -: SH]) == '0;

			always_ff @(posedge clk) begin
				if (en) begin
					nn_s[ln][n] <= top_zero ? (n_in << SH) : n_in;
					nd_s[ln][n] <= top_zero ? (d_in << SH) : d_in;
					nz_s[ln][n] <= nz_in;
				end
			end
		end

		for (genvar i = 0; i < NC; i++) begin : g_rot
			logic signed [CB-1:0] xi;
			logic signed [CB-1:0] yi;
			logic signed [CB-1:0] xsh;
			logic signed [CB-1:0] ysh;
			logic signed [ZB-1:0] zi;
			logic                 czi;
			if (i == 0) begin : g_head
				// top NB bits of the frame: the larger operand lands in [2^(NB-1), 2^NB)
				assign xi  = $signed(CB'(nd_s[ln][NS-1][W-1 -: NB]));
				assign yi  = $signed(CB'(nn_s[ln][NS-1][W-1 -: NB]));
				assign zi  = '0;
				assign czi = nz_s[ln][NS-1];
			end else begin : g_body
				assign xi  = x_s[ln][i-1];
				assign yi  = y_s[ln][i-1];
				assign zi  = z_s[ln][i-1];
				assign czi = cz_s[ln][i-1];
			end
			assign xsh = xi >>> i;
			assign ysh = yi >>> i;

			always_ff @(posedge clk) begin
				if (en) begin
					if (!yi[CB-1]) begin
						x_s[ln][i] <= xi + ysh;
						y_s[ln][i] <= yi - xsh;
						z_s[ln][i] <= zi + tppe_pkg::ATAN_TAB[i];
					end else begin
						x_s[ln][i] <= xi - ysh;
						y_s[ln][i] <= yi + xsh;
						z_s[ln][i] <= zi - tppe_pkg::ATAN_TAB[i];
					end
					cz_s[ln][i] <= czi;
				end
			end
		end

		logic signed [ZB-1:0] z_rnd;
		logic signed [ZB-1:0] z_deg;
		assign z_rnd = z_s[ln][NC-1] + ZB'(1 << (ZSH - 1));
		assign z_deg = z_rnd >>> ZSH;

		always_ff @(posedge clk) begin
			if (en) begin
				priority if (!cz_s[ln][NC-1] || z_deg[ZB-1]) begin
					ang_s[ln] <= '0;
				end else if (z_deg > $signed(ZB'(tppe_pkg::ANGLE_TOP))) begin
					ang_s[ln] <= tppe_pkg::ANGLE_TOP;
				end else begin
					ang_s[ln] <= z_deg[AB-1:0];
				end
			end
		end

		assign ang[ln] = ang_s[ln];
	end

	assign out_vld  = vld_s[L-1];
	assign side_out = side_s[L-1];
endmodule
`default_nettype wire

### rtl/target_pair_pose_estimator.sv
// Range, bearing and skew of a pair of targets seen by a pinhole camera.
// Input channel (item_valid/item_ready): pixel columns, pixel heights and real
// heights of the left and right target. Output channel (result_valid/
// result_ready): mean range and mean lateral offset in mm, mean yaw and skew
// in degrees with 8 fraction bits. One result per transaction, in order.
// Configuration sits on an APB port: focal length at 0x0, image width at 0x4;
// write only while no transaction is in flight.
// The pipeline takes one transaction per cycle while it is not stalled: two
// 44-stage pipelined restoring dividers (range, then lateral offset), a 6-stage
// normalizer and a 28-stage CORDIC lie between input and result.
// Backpressure stalls the whole pipeline in place; item_ready drops only
// while a result waits in the output register and result_ready is low.
// Reset clears every valid bit and loads focal 600 and width 640.
`default_nettype none
`include "target_pair_pose_estimator_macros.svh"
module target_pair_pose_estimator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [tppe_pkg::APB_ADDR_BITS-1:0]    paddr,
	input  logic [tppe_pkg::APB_DATA_BITS-1:0]    pwdata,
	output logic [tppe_pkg::APB_DATA_BITS-1:0]    prdata,
	output logic                                  pready,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  logic [tppe_pkg::PIXEL_BITS-1:0]       left_col,
	input  logic [tppe_pkg::PIXEL_BITS-1:0]       right_col,
	input  logic [tppe_pkg::PIXEL_BITS-1:0]       left_pix_height,
	input  logic [tppe_pkg::PIXEL_BITS-1:0]       right_pix_height,
	input  logic [tppe_pkg::TRUE_BITS-1:0]        left_true_height,
	input  logic [tppe_pkg::TRUE_BITS-1:0]        right_true_height,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic [tppe_pkg::MEAN_RANGE_BITS-1:0]  mean_range,
	output logic signed [tppe_pkg::ANGLE_BITS-1:0] mean_yaw,
	output logic signed [tppe_pkg::MEAN_LAT_BITS-1:0] mean_lateral,
	output logic signed [tppe_pkg::ANGLE_BITS-1:0] skew_angle
);
	localparam int PB  = tppe_pkg::PIXEL_BITS;
	localparam int FB  = tppe_pkg::FOCAL_BITS;
	localparam int WB  = tppe_pkg::WIDTH_BITS;
	localparam int RB  = tppe_pkg::RANGE_BITS;
	localparam int DB  = tppe_pkg::DIV_BITS;
	localparam int LB  = tppe_pkg::LAT_BITS;
	localparam int IB  = tppe_pkg::ATAN_IN_BITS;
	localparam int AB  = tppe_pkg::ANGLE_MAG_BITS;
	localparam int GB  = tppe_pkg::ANGLE_BITS;
	localparam int MRB = tppe_pkg::MEAN_RANGE_BITS;
	localparam int MLB = tppe_pkg::MEAN_LAT_BITS;
	localparam int NL  = tppe_pkg::ATAN_LANES;
	localparam logic signed [AB+1:0] ANG_HI = (AB+2)'((1 << (GB - 1)) - 1);
	localparam logic signed [AB+1:0] ANG_LO = -(AB+2)'(1 << (GB - 1));
	localparam logic signed [LB:0]   LAT_HI = (LB+1)'((1 << (MLB - 1)) - 1);
	localparam logic signed [LB:0]   LAT_LO = -LAT_HI;
	localparam logic signed [GB-1:0] ANG_LIM = GB'(tppe_pkg::ANGLE_TOP);

	// ---------------- configuration ----------------
	logic [FB-1:0] focal_q;
	logic [WB-1:0] width_q;
	tppe_pkg::reg_idx_t reg_idx;

	assign reg_idx = tppe_pkg::reg_idx_t'(paddr[tppe_pkg::APB_ADDR_BITS-1:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q <= tppe_pkg::FOCAL_RESET;
			width_q <= tppe_pkg::WIDTH_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				tppe_pkg::REG_FOCAL: focal_q <= pwdata[FB-1:0];
				tppe_pkg::REG_WIDTH: width_q <= pwdata[WB-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			tppe_pkg::REG_FOCAL: prdata = tppe_pkg::APB_DATA_BITS'(focal_q);
			tppe_pkg::REG_WIDTH: prdata = tppe_pkg::APB_DATA_BITS'(width_q);
			default:             prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	logic result_valid_q;
	logic en;

	assign en         = !result_valid_q || result_ready;
	assign item_ready = en;

	// ---------------- stage 1: range numerator, column offset ----------------
	logic [FB-1:0]       f1;
	logic [WB-2:0]       center;
	logic signed [WB:0]  dx_l, dx_r;
	logic                vld_s1;
	logic [RB-1:0]       prod_l_s1, prod_r_s1;
	logic [PB-1:0]       ph_l_s1, ph_r_s1;
	tppe_pkg::div_side_t side_s1;

	assign f1     = (focal_q == '0) ? FB'(1) : focal_q;
	assign center = width_q[WB-1:1];
	assign dx_l   = $signed((WB+1)'(left_col)) - $signed((WB+1)'(center));
	assign dx_r   = $signed((WB+1)'(right_col)) - $signed((WB+1)'(center));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_l_s1     <= RB'(left_true_height) * RB'(f1);
			prod_r_s1     <= RB'(right_true_height) * RB'(f1);
			ph_l_s1       <= (left_pix_height == '0) ? PB'(1) : left_pix_height;
			ph_r_s1       <= (right_pix_height == '0) ? PB'(1) : right_pix_height;
			side_s1.adx_l <= PB'(dx_l[WB] ? -dx_l : dx_l);
			side_s1.adx_r <= PB'(dx_r[WB] ? -dx_r : dx_r);
			side_s1.neg_l <= dx_l[WB];
			side_s1.neg_r <= dx_r[WB];
			side_s1.focal <= f1;
			side_s1.rng_l <= '0;
			side_s1.rng_r <= '0;
		end
	end

	// ---------------- range divider ----------------
	logic                vld_a;
	logic [DB-1:0]       rq_l, rq_r;
	tppe_pkg::div_side_t side_a;

	tppe_div2 u_div_range (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s1),
		.dvd_l    (DB'(prod_l_s1)),
		.dvd_r    (DB'(prod_r_s1)),
		.dvs_l    (FB'(ph_l_s1)),
		.dvs_r    (FB'(ph_r_s1)),
		.side_in  (side_s1),
		.out_vld  (vld_a),
		.quo_l    (rq_l),
		.quo_r    (rq_r),
		.side_out (side_a)
	);

	// ---------------- stage 2: range * |dx| ----------------
	logic                vld_s2;
	logic [DB-1:0]       mul_l_s2, mul_r_s2;
	tppe_pkg::div_side_t side_a_rng;
	tppe_pkg::div_side_t side_s2;

	always_comb begin
		side_a_rng       = side_a;
		side_a_rng.rng_l = rq_l[RB-1:0];
		side_a_rng.rng_r = rq_r[RB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mul_l_s2 <= DB'(rq_l[RB-1:0]) * DB'(side_a.adx_l);
			mul_r_s2 <= DB'(rq_r[RB-1:0]) * DB'(side_a.adx_r);
			side_s2  <= side_a_rng;
		end
	end

	// ---------------- lateral divider ----------------
	logic                vld_b;
	logic [DB-1:0]       lm_l, lm_r;
	tppe_pkg::div_side_t side_b;

	tppe_div2 u_div_lat (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s2),
		.dvd_l    (mul_l_s2),
		.dvd_r    (mul_r_s2),
		.dvs_l    (side_s2.focal),
		.dvs_r    (side_s2.focal),
		.side_in  (side_s2),
		.out_vld  (vld_b),
		.quo_l    (lm_l),
		.quo_r    (lm_r),
		.side_out (side_b)
	);

	// ---------------- stage 3: signed lateral ----------------
	logic                vld_s3;
	logic signed [LB-1:0] lat_l_s3, lat_r_s3;
	tppe_pkg::div_side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_b;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lat_l_s3 <= side_b.neg_l ? -$signed({1'b0, lm_l}) : $signed({1'b0, lm_l});
			lat_r_s3 <= side_b.neg_r ? -$signed({1'b0, lm_r}) : $signed({1'b0, lm_r});
			side_s3  <= side_b;
		end
	end

	// ---------------- stage 4: atan operands and sums ----------------
	logic signed [LB:0]   dy_p, dy_n;
	logic [RB-1:0]        dr;
	logic                 vld_s4;
	logic [IB-1:0]        num_s4 [NL];
	logic [IB-1:0]        den_s4 [NL];
	tppe_pkg::atan_side_t side_s4;

	assign dy_p = $signed((LB+1)'(lat_l_s3)) - $signed((LB+1)'(lat_r_s3));
	assign dy_n = $signed((LB+1)'(lat_r_s3)) - $signed((LB+1)'(lat_l_s3));
	assign dr   = (side_s3.rng_r >= side_s3.rng_l) ? side_s3.rng_r - side_s3.rng_l
	                                               : side_s3.rng_l - side_s3.rng_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4[tppe_pkg::LANE_YAW_L] <= IB'(side_s3.adx_l);
			den_s4[tppe_pkg::LANE_YAW_L] <= IB'(side_s3.focal);
			num_s4[tppe_pkg::LANE_YAW_R] <= IB'(side_s3.adx_r);
			den_s4[tppe_pkg::LANE_YAW_R] <= IB'(side_s3.focal);
			num_s4[tppe_pkg::LANE_SKEW]  <= dy_p[LB] ? IB'(dy_n) : IB'(dy_p);
			den_s4[tppe_pkg::LANE_SKEW]  <= IB'(dr);
			side_s4.neg_yaw_l <= side_s3.neg_l;
			side_s4.neg_yaw_r <= side_s3.neg_r;
			side_s4.neg_skew  <= dy_p[LB];
			side_s4.rng_sum   <= (RB+1)'(side_s3.rng_l) + (RB+1)'(side_s3.rng_r);
			side_s4.lat_sum   <= $signed((LB+1)'(lat_l_s3)) + $signed((LB+1)'(lat_r_s3));
		end
	end

	// ---------------- angles ----------------
	logic                 vld_c;
	logic [AB-1:0]        ang_c [NL];
	tppe_pkg::atan_side_t side_c;

	tppe_atan3 u_atan (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.num      (num_s4),
		.den      (den_s4),
		.side_in  (side_s4),
		.out_vld  (vld_c),
		.ang      (ang_c),
		.side_out (side_c)
	);

	// ---------------- output stage ----------------
	logic signed [AB:0]   yaw_l, yaw_r, skew_v;
	logic signed [AB+1:0] yaw_sum, yaw_mean, skew_x;
	logic [RB-1:0]        rng_half;
	logic signed [LB:0]   lat_adj, lat_half;
	logic [MRB-1:0]       mean_range_q;
	logic signed [GB-1:0] mean_yaw_q, skew_q;
	logic signed [MLB-1:0] mean_lat_q;

	assign yaw_l    = side_c.neg_yaw_l ? -$signed({1'b0, ang_c[tppe_pkg::LANE_YAW_L]})
	                                   : $signed({1'b0, ang_c[tppe_pkg::LANE_YAW_L]});
	assign yaw_r    = side_c.neg_yaw_r ? -$signed({1'b0, ang_c[tppe_pkg::LANE_YAW_R]})
	                                   : $signed({1'b0, ang_c[tppe_pkg::LANE_YAW_R]});
	assign skew_v   = side_c.neg_skew ? -$signed({1'b0, ang_c[tppe_pkg::LANE_SKEW]})
	                                  : $signed({1'b0, ang_c[tppe_pkg::LANE_SKEW]});
	assign yaw_sum  = $signed((AB+2)'(yaw_l)) + $signed((AB+2)'(yaw_r));
	assign yaw_mean = yaw_sum >>> 1;
	assign skew_x   = $signed((AB+2)'(skew_v));
	assign rng_half = side_c.rng_sum[RB:1];
	// truncate toward zero: bias negative sums by one before the shift
	assign lat_adj  = side_c.lat_sum + (LB+1)'(side_c.lat_sum[LB]);
	assign lat_half = lat_adj >>> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (en) begin
			result_valid_q <= vld_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (rng_half[RB-1:MRB] != '0) begin
				mean_range_q <= '1;
			end else begin
				mean_range_q <= rng_half[MRB-1:0];
			end

			priority if (yaw_mean > ANG_HI) begin
				mean_yaw_q <= GB'(ANG_HI);
			end else if (yaw_mean < ANG_LO) begin
				mean_yaw_q <= GB'(ANG_LO);
			end else begin
				mean_yaw_q <= GB'(yaw_mean);
			end

			priority if (skew_x > ANG_HI) begin
				skew_q <= GB'(ANG_HI);
			end else if (skew_x < ANG_LO) begin
				skew_q <= GB'(ANG_LO);
			end else begin
				skew_q <= GB'(skew_x);
			end

			priority if (lat_half > LAT_HI) begin
				mean_lat_q <= MLB'(LAT_HI);
			end else if (lat_half < LAT_LO) begin
				mean_lat_q <= MLB'(LAT_LO);
			end else begin
				mean_lat_q <= MLB'(lat_half);
			end
		end
	end

	assign result_valid = result_valid_q;
	assign mean_range   = mean_range_q;
	assign mean_yaw     = mean_yaw_q;
	assign mean_lateral = mean_lat_q;
	assign skew_angle   = skew_q;

	`TPPE_ASSERT_IMP(a_yaw_range, clk, arst_n, result_valid,
		(mean_yaw <= ANG_LIM) && (mean_yaw >= -ANG_LIM), "mean yaw beyond 90 degrees")
	`TPPE_ASSERT_IMP(a_skew_range, clk, arst_n, result_valid,
		(skew_angle <= ANG_LIM) && (skew_angle >= -ANG_LIM), "skew beyond 90 degrees")
	`TPPE_ASSERT_NXT(a_stall_hold, clk, arst_n, !item_ready,
		$stable(vld_s1) && $stable(vld_s4) && $stable(prod_l_s1), "pipeline moved during stall")
endmodule
`default_nettype wire

### verif/target_pair_pose_estimator_tb.sv
`default_nettype none
module target_pair_pose_estimator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 2000000;
	localparam int LATENCY = 127;

	typedef struct packed {
		logic [11:0] lcol;
		logic [11:0] rcol;
		logic [11:0] lph;
		logic [11:0] rph;
		logic [15:0] lth;
		logic [15:0] rth;
	} pair_t;

	typedef struct packed {
		logic [19:0]        rng;
		logic signed [15:0] yaw;
		logic signed [20:0] lat;
		logic signed [15:0] skew;
	} pose_t;

	typedef struct {
		pair_t p;
		bit    has_want;
		pose_t want;
	} row_t;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [tppe_pkg::APB_ADDR_BITS-1:0] paddr = '0;
	logic [tppe_pkg::APB_DATA_BITS-1:0] pwdata = '0;
	logic [tppe_pkg::APB_DATA_BITS-1:0] prdata;
	logic pready;
	logic item_valid = 0, item_ready;
	logic [11:0] left_col = 0, right_col = 0, left_pix_height = 1, right_pix_height = 1;
	logic [15:0] left_true_height = 0, right_true_height = 0;
	logic result_valid, result_ready = 0;
	logic [19:0] mean_range;
	logic signed [15:0] mean_yaw, skew_angle;
	logic signed [20:0] mean_lateral;

	target_pair_pose_estimator dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	logic [15:0] focal_q;
	logic [12:0] width_q;
	pose_t pose_q[$];
	int errors = 0;
	int cycles = 0;
	bit calm = 0;
	bit done = 0;

	// atan(num/den) in degrees, 8 fraction bits, 0..90
	function automatic longint atan_q8(longint unsigned num, longint unsigned den);
		longint unsigned m;
		longint x, y, z, xs, ys, r;
		z = 0;
		if (num == 0) return 0;
		m = num > den ? num : den;
		while (m >= (64'd1 << 39)) begin
			num >>= 1; den >>= 1; m >>= 1;
		end
		while (m < (64'd1 << 38)) begin
			num <<= 1; den <<= 1; m <<= 1;
		end
		x = den;
		y = num;
		for (int i = 0; i < tppe_pkg::CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += longint'(tppe_pkg::ATAN_TAB[i]);
			end else begin
				x -= ys; y += xs; z -= longint'(tppe_pkg::ATAN_TAB[i]);
			end
		end
		r = (z + (64'sd1 << 15)) >>> 16;
		if (r < 0) r = 0;
		if (r > (90 << 8)) r = 90 << 8;
		return r;
	endfunction

	function automatic longint sat16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic pose_t estimate_pose(pair_t p);
		longint unsigned f, ph, th, adx, lm;
		longint center, dx, a, sum, mr, ml, dy, my, sk;
		longint unsigned dr;
		longint rng[2], lat[2], yaw[2];
		pose_t o;
		f = focal_q == 0 ? 1 : focal_q;
		center = width_q >> 1;
		for (int k = 0; k < 2; k++) begin
			dx = longint'(k == 0 ? p.lcol : p.rcol) - center;
			ph = k == 0 ? p.lph : p.rph;
			th = k == 0 ? p.lth : p.rth;
			adx = dx < 0 ? -dx : dx;
			if (ph == 0) ph = 1;
			rng[k] = (th * f) / ph;
			lm = (rng[k] * adx) / f;
			lat[k] = dx < 0 ? -longint'(lm) : longint'(lm);
			a = atan_q8(adx, f);
			yaw[k] = dx < 0 ? -a : a;
		end
		mr = (rng[0] + rng[1]) >> 1;
		if (mr > 1048575) mr = 1048575;
		my = sat16((yaw[0] + yaw[1]) >>> 1);
		sum = lat[0] + lat[1];
		ml = sum < 0 ? -((-sum) / 2) : sum / 2;
		if (ml > 1048575) ml = 1048575;
		if (ml < -1048575) ml = -1048575;
		dy = lat[0] - lat[1];
		dr = rng[1] >= rng[0] ? rng[1] - rng[0] : rng[0] - rng[1];
		if (dy == 0) sk = 0;
		else begin
			a = atan_q8(dy < 0 ? -dy : dy, dr);
			sk = dy < 0 ? -a : a;
		end
		o.rng = mr[19:0];
		o.yaw = my[15:0];
		o.lat = ml[20:0];
		o.skew = sat16(sk);
		return o;
	endfunction

	task automatic reg_write(tppe_pkg::reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= tppe_pkg::APB_ADDR_BITS'(idx) << 2;
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == tppe_pkg::REG_FOCAL) focal_q = val[15:0];
		else width_q = val[12:0];
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// called at a falling edge; returns at a falling edge
	task automatic drain;
		item_valid <= 0;
		while (pose_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		@(negedge clk);
	endtask

	// called at a falling edge; returns at the falling edge after acceptance,
	// with valid still high so the next transaction can follow with no gap
	task automatic send_pair(pair_t p, bit has_want, pose_t want);
		while (!calm && $urandom_range(99) < 25) begin
			item_valid <= 0;
			@(negedge clk);
		end
		item_valid <= 1;
		{left_col, right_col, left_pix_height, right_pix_height,
			left_true_height, right_true_height} <= p;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		pose_q.push_back(has_want ? want : estimate_pose(p));
		@(negedge clk);
	endtask

	function automatic pair_t rand_pair(bit tidy);
		pair_t p;
		p = $urandom;
		p.lth = $urandom;
		p.rth = $urandom;
		p.lcol = $urandom;
		p.rcol = $urandom;
		p.lph = $urandom;
		p.rph = $urandom;
		if (tidy) begin
			p.lph = $urandom_range(4095, 1);
			p.rph = $urandom_range(4095, 1);
			if ($urandom_range(3) == 0) begin
				p.lph = $urandom_range(60, 1);
				p.rph = $urandom_range(60, 1);
			end
			if ($urandom_range(7) == 0) begin
				p.rph = p.lph; p.rth = p.lth;
			end
		end
		return p;
	endfunction

	always @(negedge clk) begin
		if (calm) result_ready <= 1;
		else result_ready <= $urandom_range(99) >= 25;
	end

	always @(posedge clk) begin
		pose_t want;
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
		if (arst_n && result_valid && result_ready) begin
			if (pose_q.size() == 0) begin
				$display("%0t: unexpected result", $realtime);
				errors++;
			end else begin
				want = pose_q.pop_front();
				if (mean_range !== want.rng) begin
					$display("%0t: mean_range exp %0d got %0d", $realtime, want.rng, mean_range);
					errors++;
				end
				if (mean_yaw !== want.yaw) begin
					$display("%0t: mean_yaw exp %0d got %0d", $realtime, want.yaw, mean_yaw);
					errors++;
				end
				if (mean_lateral !== want.lat) begin
					$display("%0t: mean_lateral exp %0d got %0d", $realtime,
						want.lat, mean_lateral);
					errors++;
				end
				if (skew_angle !== want.skew) begin
					$display("%0t: skew_angle exp %0d got %0d", $realtime,
						want.skew, skew_angle);
					errors++;
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		pose_t z;
		int fsets[5];
		int wsets[5];
		z = '0;
		fsets = '{600, 1, 65535, 0, 320};
		wsets = '{640, 2, 4096, 8191, 1000};
		focal_q = 600;
		width_q = 640;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// after reset: centered targets, zero height gives zero everything
		r.has_want = 1;
		r.p = {12'd320, 12'd320, 12'd10, 12'd10, 16'd0, 16'd0};
		r.want = z;
		rows.push_back(r);
		r.p = {12'd320, 12'd320, 12'd1, 12'd1, 16'd1000, 16'd1000};
		r.want = '{rng: 20'd600000, yaw: 16'sd0, lat: 21'sd0, skew: 16'sd0};
		rows.push_back(r);
		// zero pixel height acts as one
		r.p = {12'd320, 12'd320, 12'd0, 12'd0, 16'd1000, 16'd1000};
		rows.push_back(r);
		// range saturation
		r.p = {12'd320, 12'd320, 12'd1, 12'd1, 16'hFFFF, 16'hFFFF};
		r.want = '{rng: 20'hFFFFF, yaw: 16'sd0, lat: 21'sd0, skew: 16'sd0};
		rows.push_back(r);
		r.has_want = 0;
		r.p = {12'd0, 12'd4095, 12'd1, 12'd1, 16'hFFFF, 16'hFFFF};
		rows.push_back(r);
		r.p = {12'd4095, 12'd0, 12'd4095, 12'd1, 16'hFFFF, 16'd1};
		rows.push_back(r);
		r.p = {12'd0, 12'd0, 12'd100, 12'd100, 16'd500, 16'd500};
		rows.push_back(r);
		r.p = {12'd100, 12'd500, 12'd50, 12'd50, 16'd500, 16'd500};
		rows.push_back(r);
		r.p = {12'd500, 12'd100, 12'd50, 12'd50, 16'd500, 16'd500};
		rows.push_back(r);
		r.p = {12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'hFFFF, 16'hFFFF};
		rows.push_back(r);
		r.p = {12'd200, 12'd400, 12'd40, 12'd80, 16'd800, 16'd300};
		rows.push_back(r);
		foreach (rows[i]) send_pair(rows[i].p, rows[i].has_want, rows[i].want);
		drain();

		for (int s = 0; s < 5; s++) begin
			reg_write(tppe_pkg::REG_FOCAL, fsets[s]);
			reg_write(tppe_pkg::REG_WIDTH, wsets[s]);
			calm = (s == 2);
			for (int n = 0; n < 200; n++) begin
				if (n == 100) drain();
				send_pair(rand_pair($urandom_range(9) != 0), 0, z);
			end
			drain();
		end
		reg_write(tppe_pkg::REG_FOCAL, 600);
		reg_write(tppe_pkg::REG_WIDTH, 640);
		calm = 0;
		for (int n = 0; n < 40; n++) send_pair(rand_pair(1), 0, z);
		drain();
		if (errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire
